/* sv/ptlrl_pkg.sv */
package ptlrl_pkg;

    localparam int KEY_W   = 16;
    localparam int SLOT_W  = 8;
    localparam int LEN_W   = 9;
    localparam int PAIR_W  = 2 * KEY_W;
    localparam int LIST_MAX = 256;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_TOUCH  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RES_WRITE,
        RES_FOUND,
        RES_MISS,
        RES_LIST
    } res_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TSCAN,
        ST_LSCAN,
        ST_SHIFT,
        ST_APPEND_NEW,
        ST_APPEND_MOVED,
        ST_LWAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic      load_in;
        logic      cnt_clear;
        logic      tab_wr;
        logic      tab_rd;
        logic      lst_rd;
        logic      lst_rd_slot;
        logic      shift_wr;
        logic      app_wr;
        logic      app_new;
        logic      res_load;
        res_kind_t res_kind;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic rd_in_len;
        logic tab_match;
        logic tab_end;
        logic len_zero;
        logic lst_match;
        logic lst_end;
        logic shift_done;
        logic out_free;
    } status_t;

endpackage

/* sv/pair_table_lookup_recency_list.sv */
// Pair table with lookup and a move-to-end recency list.
//
// Input channel s_*: one transaction per operation. s_tuser carries the
// operation code and the half selector, s_tdata the key, the second half
// and the slot or list position. Output channel m_*: exactly one result
// transaction per input transaction, in order.
//
// Operations run one at a time. A lookup scans the table one slot per cycle
// through the pair memory's registered read port. A touch adds a scan of the
// list and a shift of the entries behind the old copy, one list entry per
// cycle through the list memory's single port pair. The next transaction can
// be taken in the cycle after a result is loaded into the output register.
//
// Reset clears the valid bits and the list length; the pair and list memories
// are not cleared. The result sits in an output register: a new transaction
// is taken while it waits, and the block holds in its final state until the
// receiver takes the previous result.
module pair_table_lookup_recency_list #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key[15:0], second_half[31:16], slot[39:32]
    input  logic [2:0]  s_tuser,   // op[1:0], which_half[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // hit[0], entry_index[8:1], other_half[24:9],
                                   // list_length[33:25], zero[39:34]
);

    ptlrl_pkg::cmd_t    cmd;
    ptlrl_pkg::status_t sts;

    logic                          out_hit;
    logic [ptlrl_pkg::SLOT_W-1:0]  out_entry_index;
    logic [ptlrl_pkg::KEY_W-1:0]   out_other_half;
    logic [ptlrl_pkg::LEN_W-1:0]   out_list_length;

    ptlrl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptlrl_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .in_op           (ptlrl_pkg::op_t'(s_tuser[1:0])),
        .in_key          (s_tdata[15:0]),
        .in_second_half  (s_tdata[31:16]),
        .in_which_half   (s_tuser[2]),
        .in_slot         (s_tdata[39:32]),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .out_hit         (out_hit),
        .out_entry_index (out_entry_index),
        .out_other_half  (out_other_half),
        .out_list_length (out_list_length)
    );

    assign m_tdata = {6'd0, out_list_length, out_other_half, out_entry_index, out_hit};

endmodule

/* sv/ptlrl_ctrl.sv */
module ptlrl_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ptlrl_pkg::status_t sts,
    output ptlrl_pkg::cmd_t    cmd
);

    ptlrl_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ptlrl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ptlrl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ptlrl_pkg::ST_DISPATCH;
                end
            end
            ptlrl_pkg::ST_DISPATCH: begin
                unique case (sts.op) inside
                    ptlrl_pkg::OP_WRITE: begin
                        cmd.tab_wr   = 1'b1;
                        cmd.res_load = 1'b1;
                        cmd.res_kind = ptlrl_pkg::RES_WRITE;
                        state_next   = ptlrl_pkg::ST_DONE;
                    end
                    ptlrl_pkg::OP_LOOKUP, ptlrl_pkg::OP_TOUCH: begin
                        cmd.cnt_clear = 1'b1;
                        state_next    = ptlrl_pkg::ST_TSCAN;
                    end
                    default: begin
                        if (sts.rd_in_len) begin
                            cmd.lst_rd_slot = 1'b1;
                            state_next      = ptlrl_pkg::ST_LWAIT;
                        end else begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = ptlrl_pkg::RES_MISS;
                            state_next   = ptlrl_pkg::ST_DONE;
                        end
                    end
                endcase
            end
            ptlrl_pkg::ST_TSCAN: begin
                cmd.tab_rd = 1'b1;
                if (sts.tab_match) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = ptlrl_pkg::RES_FOUND;
                    if (sts.op == ptlrl_pkg::OP_TOUCH) begin
                        cmd.cnt_clear = 1'b1;
                        state_next = sts.len_zero ? ptlrl_pkg::ST_APPEND_NEW
                                                  : ptlrl_pkg::ST_LSCAN;
                    end else begin
                        state_next = ptlrl_pkg::ST_DONE;
                    end
                end else if (sts.tab_end) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = ptlrl_pkg::RES_MISS;
                    state_next   = ptlrl_pkg::ST_DONE;
                end
            end
            ptlrl_pkg::ST_LSCAN: begin
                cmd.lst_rd = 1'b1;
                if (sts.lst_match) begin
                    // the read after the match is already in flight: shift from there
                    state_next = ptlrl_pkg::ST_SHIFT;
                end else if (sts.lst_end) begin
                    state_next = ptlrl_pkg::ST_APPEND_NEW;
                end
            end
            ptlrl_pkg::ST_SHIFT: begin
                cmd.lst_rd   = 1'b1;
                cmd.shift_wr = 1'b1;
                if (sts.shift_done) begin
                    state_next = ptlrl_pkg::ST_APPEND_MOVED;
                end
            end
            ptlrl_pkg::ST_APPEND_NEW: begin
                cmd.app_wr  = 1'b1;
                cmd.app_new = 1'b1;
                state_next  = ptlrl_pkg::ST_DONE;
            end
            ptlrl_pkg::ST_APPEND_MOVED: begin
                cmd.app_wr = 1'b1;
                state_next = ptlrl_pkg::ST_DONE;
            end
            ptlrl_pkg::ST_LWAIT: begin
                cmd.res_load = 1'b1;
                cmd.res_kind = ptlrl_pkg::RES_LIST;
                state_next   = ptlrl_pkg::ST_DONE;
            end
            ptlrl_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ptlrl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ptlrl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/ptlrl_dpath.sv */
module ptlrl_dpath #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ptlrl_pkg::cmd_t                cmd,
    output ptlrl_pkg::status_t             sts,
    input  ptlrl_pkg::op_t                 in_op,
    input  logic [ptlrl_pkg::KEY_W-1:0]    in_key,
    input  logic [ptlrl_pkg::KEY_W-1:0]    in_second_half,
    input  logic                           in_which_half,
    input  logic [ptlrl_pkg::SLOT_W-1:0]   in_slot,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic                           out_hit,
    output logic [ptlrl_pkg::SLOT_W-1:0]   out_entry_index,
    output logic [ptlrl_pkg::KEY_W-1:0]    out_other_half,
    output logic [ptlrl_pkg::LEN_W-1:0]    out_list_length
);

    // only slots reachable by the 8-bit slot field are ever stored
    localparam int STORE_N = (TABLE_ENTRIES < ptlrl_pkg::LIST_MAX) ? TABLE_ENTRIES
                                                                   : ptlrl_pkg::LIST_MAX;
    localparam int SIDX_W  = $clog2(STORE_N);
    localparam int CNT_W   = $clog2(STORE_N + 1);

    localparam int KW = ptlrl_pkg::KEY_W;
    localparam int SW = ptlrl_pkg::SLOT_W;
    localparam int LW = ptlrl_pkg::LEN_W;

    logic [ptlrl_pkg::PAIR_W-1:0] pair_mem [STORE_N];
    logic [SW-1:0]                list_mem [STORE_N];
    logic [STORE_N-1:0]           valid_reg;

    ptlrl_pkg::op_t op_reg;
    logic [KW-1:0]  key_reg;
    logic [KW-1:0]  second_reg;
    logic           which_reg;
    logic [SW-1:0]  slot_reg;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] len_reg;

    logic                         tpend_reg;
    logic                         tvld_reg;
    logic [SIDX_W-1:0]            taddr_reg;
    logic [ptlrl_pkg::PAIR_W-1:0] tdata_reg;

    logic              lpend_reg;
    logic [SIDX_W-1:0] laddr_reg;
    logic [SW-1:0]     ldata_reg;

    logic          res_hit_reg;
    logic [SW-1:0] res_idx_reg;
    logic [KW-1:0] res_other_reg;

    logic          m_tvalid_reg;
    logic          o_hit_reg;
    logic [SW-1:0] o_idx_reg;
    logic [KW-1:0] o_other_reg;
    logic [LW-1:0] o_len_reg;

    logic              in_range;
    logic              cmp_b;
    logic [KW-1:0]     cmp_half;
    logic [KW-1:0]     rest_half;
    logic              issue_tab;
    logic              issue_lst;
    logic [SIDX_W-1:0] lst_raddr;
    logic [CNT_W-1:0]  len_m1;
    logic              lst_we;
    logic [SIDX_W-1:0] lst_waddr;
    logic [SW-1:0]     lst_wdata;

    assign in_range  = {1'b0, slot_reg} < LW'(STORE_N);
    assign cmp_b     = which_reg && (op_reg == ptlrl_pkg::OP_LOOKUP);
    assign cmp_half  = cmp_b ? tdata_reg[2*KW-1:KW] : tdata_reg[KW-1:0];
    assign rest_half = cmp_b ? tdata_reg[KW-1:0] : tdata_reg[2*KW-1:KW];
    assign issue_tab = cmd.tab_rd && (cnt_reg < CNT_W'(STORE_N));
    assign issue_lst = cmd.lst_rd && (cnt_reg < len_reg);
    assign lst_raddr = cmd.lst_rd_slot ? slot_reg[SIDX_W-1:0] : cnt_reg[SIDX_W-1:0];
    assign len_m1    = len_reg - 1'b1;

    always_comb begin
        lst_we    = 1'b0;
        lst_waddr = laddr_reg - 1'b1;
        lst_wdata = ldata_reg;
        if (cmd.app_wr) begin
            lst_we    = 1'b1;
            lst_waddr = cmd.app_new ? len_reg[SIDX_W-1:0] : len_m1[SIDX_W-1:0];
            lst_wdata = res_idx_reg;
        end else if (cmd.shift_wr && lpend_reg) begin
            lst_we = 1'b1;
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg     <= in_op;
            key_reg    <= in_key;
            second_reg <= in_second_half;
            which_reg  <= in_which_half;
            slot_reg   <= in_slot;
        end
    end

    // pair table and valid bits
    always_ff @(posedge aclk) begin
        if (cmd.tab_wr && in_range) begin
            pair_mem[slot_reg[SIDX_W-1:0]] <= {second_reg, key_reg};
        end
        tdata_reg <= pair_mem[cnt_reg[SIDX_W-1:0]];
        tvld_reg  <= valid_reg[cnt_reg[SIDX_W-1:0]];
        taddr_reg <= cnt_reg[SIDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.tab_wr && in_range) begin
            valid_reg[slot_reg[SIDX_W-1:0]] <= 1'b1;
        end
    end

    // recency list
    always_ff @(posedge aclk) begin
        if (lst_we) begin
            list_mem[lst_waddr] <= lst_wdata;
        end
        ldata_reg <= list_mem[lst_raddr];
        laddr_reg <= lst_raddr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            cnt_reg   <= '0;
            tpend_reg <= 1'b0;
            lpend_reg <= 1'b0;
        end else begin
            tpend_reg <= issue_tab;
            lpend_reg <= issue_lst;
            if (cmd.cnt_clear) begin
                cnt_reg <= '0;
            end else if (issue_tab || issue_lst) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.app_wr && cmd.app_new) begin
                len_reg <= len_reg + 1'b1;
            end
        end
    end

    // result
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            case (cmd.res_kind)
                ptlrl_pkg::RES_WRITE: begin
                    res_hit_reg   <= in_range;
                    res_idx_reg   <= slot_reg;
                    res_other_reg <= '0;
                end
                ptlrl_pkg::RES_FOUND: begin
                    res_hit_reg   <= 1'b1;
                    res_idx_reg   <= SW'(taddr_reg);
                    res_other_reg <= rest_half;
                end
                ptlrl_pkg::RES_LIST: begin
                    res_hit_reg   <= 1'b1;
                    res_idx_reg   <= ldata_reg;
                    res_other_reg <= '0;
                end
                default: begin
                    res_hit_reg   <= 1'b0;
                    res_idx_reg   <= '0;
                    res_other_reg <= '0;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_hit_reg   <= res_hit_reg;
            o_idx_reg   <= res_idx_reg;
            o_other_reg <= res_other_reg;
            o_len_reg   <= LW'(len_reg);
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign out_hit         = o_hit_reg;
    assign out_entry_index = o_idx_reg;
    assign out_other_half  = o_other_reg;
    assign out_list_length = o_len_reg;

    assign sts.op         = op_reg;
    assign sts.rd_in_len  = {1'b0, slot_reg} < LW'(len_reg);
    assign sts.tab_match  = tpend_reg && tvld_reg && (cmp_half == key_reg);
    assign sts.tab_end    = tpend_reg && (taddr_reg == SIDX_W'(STORE_N - 1));
    assign sts.len_zero   = (len_reg == '0);
    assign sts.lst_match  = lpend_reg && (ldata_reg == res_idx_reg);
    assign sts.lst_end    = lpend_reg && (laddr_reg == len_m1[SIDX_W-1:0]);
    assign sts.shift_done = !lpend_reg && !(cnt_reg < len_reg);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= CNT_W'(STORE_N))
        else $error("recency list longer than the table");

    a_len_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.app_wr && cmd.app_new) |=> $stable(len_reg))
        else $error("list length changed without a new append");

    a_shift_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.shift_wr && lpend_reg) |->
            (laddr_reg != '0) && (CNT_W'(laddr_reg) < len_reg))
        else $error("shift write outside the list");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=>
            m_tvalid_reg && $stable({o_hit_reg, o_idx_reg, o_other_reg, o_len_reg}))
        else $error("result changed while the receiver stalled");
`endif

endmodule

/* tb/pair_table_lookup_recency_list_test.sv */
module pair_table_lookup_recency_list_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4096;
    localparam int RANDOM_OPS  = 650;
    localparam int TABLE_SIZE  = 256;

    typedef struct packed {
        ptlrl_pkg::op_t op;
        logic [15:0]    key;
        logic [15:0]    second;
        logic           half;
        logic [7:0]     slot;
    } pair_cmd_t;

    typedef struct packed {
        logic        hit;
        logic [7:0]  idx;
        logic [15:0] other;
        logic [8:0]  len;
    } pair_reply_t;

    typedef struct packed {
        pair_cmd_t   cmd;
        logic        typed;
        pair_reply_t want;
    } dir_row_t;

    localparam pair_reply_t NONE = '0;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;

    // shadow of the pair table and the recency list
    logic [15:0] tab_a [TABLE_SIZE];
    logic [15:0] tab_b [TABLE_SIZE];
    bit          tab_ok [TABLE_SIZE];
    logic [7:0]  recency_q [$];

    pair_reply_t results_due [$];
    pair_reply_t head_reply;
    logic [15:0] key_pool [16];
    bit          quiet = 1'b0;
    int          err_count = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;

    // first rows: reset state, extremes, duplicate keys, list removal at front and middle
    dir_row_t dir_rows [25] = '{
        '{'{ptlrl_pkg::OP_READ, 16'h0000, 16'h0000, 1'b0, 8'd0}, 1'b1,
          '{1'b0, 8'd0, 16'h0, 9'd0}},
        '{'{ptlrl_pkg::OP_LOOKUP, 16'h0000, 16'h0000, 1'b0, 8'd0}, 1'b1,
          '{1'b0, 8'd0, 16'h0, 9'd0}},
        '{'{ptlrl_pkg::OP_TOUCH, 16'h0000, 16'h0000, 1'b0, 8'd0}, 1'b1,
          '{1'b0, 8'd0, 16'h0, 9'd0}},
        '{'{ptlrl_pkg::OP_LOOKUP, 16'hFFFF, 16'hFFFF, 1'b1, 8'd255}, 1'b1,
          '{1'b0, 8'd0, 16'h0, 9'd0}},
        '{'{ptlrl_pkg::OP_WRITE, 16'h8000, 16'h7FFF, 1'b0, 8'd0}, 1'b1,
          '{1'b1, 8'd0, 16'h0, 9'd0}},
        '{'{ptlrl_pkg::OP_WRITE, 16'h7FFF, 16'h8000, 1'b1, 8'd255}, 1'b1,
          '{1'b1, 8'd255, 16'h0, 9'd0}},
        '{'{ptlrl_pkg::OP_WRITE, 16'h8000, 16'hFFFF, 1'b0, 8'd7}, 1'b1,
          '{1'b1, 8'd7, 16'h0, 9'd0}},
        '{'{ptlrl_pkg::OP_LOOKUP, 16'h8000, 16'h0000, 1'b0, 8'd0},   1'b0, NONE},
        '{'{ptlrl_pkg::OP_LOOKUP, 16'h8000, 16'h0000, 1'b1, 8'd0},   1'b0, NONE},
        '{'{ptlrl_pkg::OP_LOOKUP, 16'hFFFF, 16'h0000, 1'b1, 8'd0},   1'b0, NONE},
        '{'{ptlrl_pkg::OP_TOUCH,  16'h7FFF, 16'h0000, 1'b0, 8'd0},   1'b0, NONE},
        '{'{ptlrl_pkg::OP_TOUCH,  16'h8000, 16'h0000, 1'b0, 8'd0},   1'b0, NONE},
        '{'{ptlrl_pkg::OP_TOUCH,  16'h7FFF, 16'h0000, 1'b0, 8'd0},   1'b0, NONE},
        '{'{ptlrl_pkg::OP_READ,   16'h0000, 16'h0000, 1'b0, 8'd0},   1'b0, NONE},
        '{'{ptlrl_pkg::OP_READ,   16'h0000, 16'h0000, 1'b0, 8'd1},   1'b0, NONE},
        '{'{ptlrl_pkg::OP_READ,   16'h0000, 16'h0000, 1'b0, 8'd2},   1'b0, NONE},
        '{'{ptlrl_pkg::OP_READ,   16'hFFFF, 16'hFFFF, 1'b1, 8'd255}, 1'b0, NONE},
        '{'{ptlrl_pkg::OP_WRITE, 16'h1234, 16'h0000, 1'b0, 8'd0}, 1'b1,
          '{1'b1, 8'd0, 16'h0, 9'd2}},
        '{'{ptlrl_pkg::OP_TOUCH,  16'h8000, 16'h0000, 1'b0, 8'd0},   1'b0, NONE},
        '{'{ptlrl_pkg::OP_TOUCH,  16'h1234, 16'h0000, 1'b0, 8'd0},   1'b0, NONE},
        '{'{ptlrl_pkg::OP_TOUCH,  16'h8000, 16'h0000, 1'b1, 8'd0},   1'b0, NONE},
        '{'{ptlrl_pkg::OP_READ,   16'h0000, 16'h0000, 1'b0, 8'd1},   1'b0, NONE},
        '{'{ptlrl_pkg::OP_LOOKUP, 16'h5555, 16'h0000, 1'b1, 8'd0},   1'b0, NONE},
        '{'{ptlrl_pkg::OP_WRITE, 16'h0000, 16'h0000, 1'b0, 8'd128}, 1'b1,
          '{1'b1, 8'd128, 16'h0, 9'd3}},
        '{'{ptlrl_pkg::OP_TOUCH,  16'h0000, 16'h0000, 1'b0, 8'd0},   1'b0, NONE}
    };

    pair_table_lookup_recency_list dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Apply one operation to the shadow state and return its result.
    function automatic pair_reply_t apply_pair_op(pair_cmd_t c);
        pair_reply_t r;
        int          found;
        int          pos;
        bit          by_b;
        r     = '0;
        found = -1;
        pos   = -1;
        by_b  = (c.op == ptlrl_pkg::OP_LOOKUP) && c.half;
        case (c.op) inside
            ptlrl_pkg::OP_WRITE: begin
                tab_a[c.slot]  = c.key;
                tab_b[c.slot]  = c.second;
                tab_ok[c.slot] = 1'b1;
                r.hit = 1'b1;
                r.idx = c.slot;
            end
            ptlrl_pkg::OP_LOOKUP, ptlrl_pkg::OP_TOUCH: begin
                for (int i = 0; i < TABLE_SIZE && found < 0; i++) begin
                    if (tab_ok[i] && (by_b ? tab_b[i] : tab_a[i]) == c.key)
                        found = i;
                end
                if (found >= 0) begin
                    r.hit   = 1'b1;
                    r.idx   = found[7:0];
                    r.other = by_b ? tab_a[found] : tab_b[found];
                    if (c.op == ptlrl_pkg::OP_TOUCH) begin
                        // drop the old copy, append at the tail
                        foreach (recency_q[k]) begin
                            if (recency_q[k] == found[7:0])
                                pos = k;
                        end
                        if (pos >= 0)
                            recency_q.delete(pos);
                        recency_q.push_back(found[7:0]);
                    end
                end
            end
            default: begin
                if (c.slot < recency_q.size()) begin
                    r.hit = 1'b1;
                    r.idx = recency_q[c.slot];
                end
            end
        endcase
        r.len = 9'(recency_q.size());
        return r;
    endfunction

    function automatic pair_cmd_t random_pair_op();
        pair_cmd_t c;
        int        pick;
        int        top;
        c.key    = ($urandom_range(0, 7) == 0) ? 16'($urandom) : key_pool[$urandom_range(0, 15)];
        c.second = $urandom_range(0, 1) ? 16'($urandom) : key_pool[$urandom_range(0, 15)];
        c.half   = 1'($urandom_range(0, 1));
        c.slot   = 8'($urandom_range(0, 255));
        pick     = $urandom_range(0, 19);
        top      = (recency_q.size() > 255) ? 255 : recency_q.size();
        if (pick < 6) begin
            c.op = ptlrl_pkg::OP_WRITE;
        end else if (pick < 11) begin
            c.op = ptlrl_pkg::OP_LOOKUP;
        end else if (pick < 16) begin
            c.op = ptlrl_pkg::OP_TOUCH;
        end else begin
            c.op = ptlrl_pkg::OP_READ;
            // mostly near the live part of the list, boundary included
            if (pick < 19)
                c.slot = 8'($urandom_range(0, top));
        end
        return c;
    endfunction

    // Drive one transaction at the falling edge, hold it until accepted.
    task automatic send_op(pair_cmd_t c, bit typed = 1'b0, pair_reply_t want = '0);
        pair_reply_t predicted;
        int          gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.slot, c.second, c.key};
        s_tuser  <= {c.half, c.op};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_pair_op(c);
        results_due.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 11) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $error("result with nothing outstanding: m_tdata %h", m_tdata);
                err_count++;
            end else begin
                head_reply = results_due.pop_front();
                if (m_tdata[0] !== head_reply.hit) begin
                    $error("hit: expected %0d, got %0d", head_reply.hit, m_tdata[0]);
                    err_count++;
                end
                if (m_tdata[8:1] !== head_reply.idx) begin
                    $error("entry_index: expected %0d, got %0d", head_reply.idx, m_tdata[8:1]);
                    err_count++;
                end
                if (m_tdata[24:9] !== head_reply.other) begin
                    $error("other_half: expected %h, got %h", head_reply.other, m_tdata[24:9]);
                    err_count++;
                end
                if (m_tdata[33:25] !== head_reply.len) begin
                    $error("list_length: expected %0d, got %0d", head_reply.len, m_tdata[33:25]);
                    err_count++;
                end
            end
        end
    end

    // end the run if neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("pair_table_lookup_recency_list_test: errors");
            $finish;
        end
    end

    initial begin
        pair_cmd_t c;
        int        visit [TABLE_SIZE];
        int        j;
        int        tmp;

        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        key_pool[2] = 16'h8000;
        key_pool[3] = 16'h7FFF;
        for (int i = 4; i < 16; i++)
            key_pool[i] = 16'($urandom);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i])
            send_op(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            send_op(random_pair_op());
        end

        // fill every slot with a distinct half a, then touch them all
        quiet = 1'b0;
        for (int s = 0; s < TABLE_SIZE; s++) begin
            c.op     = ptlrl_pkg::OP_WRITE;
            c.key    = {8'($urandom), 8'(s)};
            c.second = 16'($urandom);
            c.half   = 1'($urandom_range(0, 1));
            c.slot   = 8'(s);
            send_op(c);
        end
        for (int i = 0; i < TABLE_SIZE; i++)
            visit[i] = i;
        for (int i = TABLE_SIZE - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = visit[i];
            visit[i] = visit[j];
            visit[j] = tmp;
        end

        quiet = 1'b1;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            c.op     = ptlrl_pkg::OP_TOUCH;
            c.key    = tab_a[visit[i]];
            c.second = 16'($urandom);
            c.half   = 1'($urandom_range(0, 1));
            c.slot   = 8'($urandom);
            send_op(c);
        end
        for (int i = 0; i < 6; i++) begin
            if (i < 4)
                c.op = ptlrl_pkg::OP_READ;
            else
                c.op = ptlrl_pkg::OP_LOOKUP;
            c.key    = tab_b[visit[i]];
            c.second = 16'h0000;
            c.half   = 1'b1;
            c.slot   = (i == 0) ? 8'd255 : 8'($urandom);
            send_op(c);
        end
        // retouch the oldest entry of a full list
        c.op   = ptlrl_pkg::OP_TOUCH;
        c.key  = tab_a[visit[0]];
        c.slot = 8'd0;
        send_op(c);
        s_tvalid <= 1'b0;

        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (err_count == 0)
            $display("pair_table_lookup_recency_list_test: clean");
        else
            $display("pair_table_lookup_recency_list_test: errors");
        $finish;
    end

endmodule
